// File: design/gcs_pkg.sv
// Shared widths, types and helpers for the Givens rotation coefficient unit.
package gcs_pkg;

	localparam int FIELD_W  = 32;
	localparam int IN_WIDTH = 32;
	localparam int OUT_FRAC = 30;
	localparam int MAG_W    = IN_WIDTH - 1;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int DEN_W    = SQ_W + 1;
	localparam int M_W      = OUT_FRAC + 2;
	localparam int R_W      = SQ_W + 2 * OUT_FRAC + 2;
	localparam int T_W      = R_W + 2;
	localparam int P_W      = M_W + DEN_W;
	localparam int EXT_W    = (M_W > FIELD_W) ? M_W : FIELD_W;
	localparam int LAT      = M_W + 4;
	localparam int SIDE_N   = M_W + 3;

	localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1) << OUT_FRAC;

	typedef struct packed {
		logic           neg;
		logic [MAG_W-1:0] mag;
	} mag_t;

	typedef struct packed {
		logic bzero;
		logic swap;
		logic same;
	} side_t;

	// saturating magnitude of a two's complement field
	function automatic mag_t mag_of(input logic [FIELD_W-1:0] raw);
		logic [IN_WIDTH-1:0] v;
		logic [IN_WIDTH-1:0] m;
		mag_t res;
		v = raw[IN_WIDTH-1:0];
		m = -v;
		res.neg = v[IN_WIDTH-1];
		if (!v[IN_WIDTH-1]) begin
			res.mag = v[MAG_W-1:0];
		end else if (m[IN_WIDTH-1]) begin
			res.mag = {MAG_W{1'b1}};
		end else begin
			res.mag = m[MAG_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [FIELD_W-1:0] sgn_out(input logic [M_W-1:0] mag, input logic neg);
		logic [EXT_W-1:0] e;
		e = EXT_W'(mag);
		if (neg) begin
			e = -e;
		end
		return e[FIELD_W-1:0];
	endfunction

endpackage

// File: design/gcs_if.sv
// Valid/ready channel interfaces for operand and coefficient words.
interface gcs_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [gcs_pkg::FIELD_W-1:0] a_value;
	logic signed [gcs_pkg::FIELD_W-1:0] b_value;
	modport source(output valid, output a_value, output b_value, input ready);
	modport sink(input valid, input a_value, input b_value, output ready);
endinterface

interface gcs_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [gcs_pkg::FIELD_W-1:0] cos_term;
	logic signed [gcs_pkg::FIELD_W-1:0] sin_term;
	modport source(output valid, output cos_term, output sin_term, input ready);
	modport sink(input valid, input cos_term, input sin_term, output ready);
endinterface

// File: design/givens_rotation_coefficients_unit.sv
// Top level of the Givens rotation coefficient unit.
//
// Operand words (a_value, b_value, signed Q15.16) arrive on the operands
// channel; one coefficient word (cos_term, sin_term, signed Q1.30) leaves on
// the coeffs channel for each operand word, in order, exactly rounded to
// nearest with ties away from zero.
// From acceptance to coeffs.valid a word passes the magnitude, squaring and
// sum stages, then one stage per result bit of the square-root ratio search,
// then the output register. Throughput is one word per cycle unless the
// receiver holds off ready; cosine and sine have separate lanes.
// The whole pipeline advances together: when the receiver holds off ready
// with a word waiting, every stage holds and operands.ready drops, so no
// word is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module givens_rotation_coefficients_unit (
	input  logic     clk,
	input  logic     arst_n,
	gcs_in_if.sink   operands,
	gcs_out_if.source coeffs
);

	logic                         adv;
	logic                         vld_s [0:gcs_pkg::LAT-1];
	gcs_pkg::side_t               side_s [0:gcs_pkg::SIDE_N-1];
	gcs_pkg::mag_t                a_s1, b_s1;
	logic [gcs_pkg::SQ_W-1:0]     asq_s2, bsq_s2;
	logic [gcs_pkg::R_W-1:0]      crem_s3, srem_s3;
	logic [gcs_pkg::DEN_W-1:0]    den_s3;
	logic [gcs_pkg::M_W-1:0]      cy, sy, cm, sm;
	gcs_pkg::side_t               side_in, side_out;
	logic [gcs_pkg::FIELD_W-1:0]  cos_nxt, sin_nxt;
	logic [gcs_pkg::FIELD_W-1:0]  cos_q, sin_q;

	assign adv            = !vld_s[gcs_pkg::LAT-1] || coeffs.ready;
	assign operands.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < gcs_pkg::LAT; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= operands.valid;
			for (int j = 1; j < gcs_pkg::LAT; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	gcs_pkg::mag_t a_in, b_in;
	assign a_in = gcs_pkg::mag_of(operands.a_value);
	assign b_in = gcs_pkg::mag_of(operands.b_value);

	always_comb begin
		side_in.bzero = b_in.mag == '0;
		side_in.swap  = b_in.mag > a_in.mag;
		side_in.same  = a_in.neg == b_in.neg;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1      <= a_in;
			b_s1      <= b_in;
			side_s[0] <= side_in;
			for (int j = 1; j < gcs_pkg::SIDE_N; j++) begin
				side_s[j] <= side_s[j-1];
			end
			asq_s2  <= gcs_pkg::SQ_W'(a_s1.mag) * gcs_pkg::SQ_W'(a_s1.mag);
			bsq_s2  <= gcs_pkg::SQ_W'(b_s1.mag) * gcs_pkg::SQ_W'(b_s1.mag);
			den_s3  <= gcs_pkg::DEN_W'(asq_s2) + gcs_pkg::DEN_W'(bsq_s2);
			crem_s3 <= gcs_pkg::R_W'(asq_s2) << (2 * gcs_pkg::OUT_FRAC + 2);
			srem_s3 <= gcs_pkg::R_W'(bsq_s2) << (2 * gcs_pkg::OUT_FRAC + 2);
			cos_q   <= cos_nxt;
			sin_q   <= sin_nxt;
		end
	end

	gcs_root_lane u_cos_lane (
		.clk    (clk),
		.adv    (adv),
		.rem_in (crem_s3),
		.den_in (den_s3),
		.quot   (cy)
	);

	gcs_root_lane u_sin_lane (
		.clk    (clk),
		.adv    (adv),
		.rem_in (srem_s3),
		.den_in (den_s3),
		.quot   (sy)
	);

	// floor(2x) -> round half up
	assign cm       = (cy + gcs_pkg::M_W'(1)) >> 1;
	assign sm       = (sy + gcs_pkg::M_W'(1)) >> 1;
	assign side_out = side_s[gcs_pkg::SIDE_N-1];

	always_comb begin
		priority if (side_out.bzero) begin
			cos_nxt = gcs_pkg::ONE_EXT[gcs_pkg::FIELD_W-1:0];
			sin_nxt = '0;
		end else if (side_out.swap) begin
			cos_nxt = gcs_pkg::sgn_out(cm, side_out.same);
			sin_nxt = gcs_pkg::sgn_out(sm, 1'b0);
		end else begin
			cos_nxt = gcs_pkg::sgn_out(cm, 1'b0);
			sin_nxt = gcs_pkg::sgn_out(sm, side_out.same);
		end
	end

	assign coeffs.valid    = vld_s[gcs_pkg::LAT-1];
	assign coeffs.cos_term = cos_q;
	assign coeffs.sin_term = sin_q;

	localparam logic signed [gcs_pkg::FIELD_W-1:0] ONE_S =
		gcs_pkg::ONE_EXT[gcs_pkg::FIELD_W-1:0];

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!operands.ready |-> coeffs.valid && !coeffs.ready)
		else $error("input stalled without an output stall");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		coeffs.valid |-> coeffs.cos_term <= ONE_S && coeffs.cos_term >= -ONE_S)
		else $error("cosine word out of range");

	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		coeffs.valid |-> coeffs.sin_term <= ONE_S && coeffs.sin_term >= -ONE_S)
		else $error("sine word out of range");

endmodule

// File: design/gcs_root_lane.sv
// Pipelined bit-per-stage search for the largest m with m*m*den <= rem_in.
module gcs_root_lane (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [gcs_pkg::R_W-1:0]   rem_in,
	input  logic [gcs_pkg::DEN_W-1:0] den_in,
	output logic [gcs_pkg::M_W-1:0]   quot
);

	logic [gcs_pkg::R_W-1:0]   rem_s [0:gcs_pkg::M_W];
	logic [gcs_pkg::P_W-1:0]   prod_s [0:gcs_pkg::M_W];
	logic [gcs_pkg::M_W-1:0]   quot_s [0:gcs_pkg::M_W];
	logic [gcs_pkg::DEN_W-1:0] den_s [0:gcs_pkg::M_W];

	assign rem_s[0]  = rem_in;
	assign prod_s[0] = '0;
	assign quot_s[0] = '0;
	assign den_s[0]  = den_in;

	genvar i;
	generate
		for (i = 1; i <= gcs_pkg::M_W; i++) begin : g_stage
			localparam int K = gcs_pkg::M_W - i;
			logic [gcs_pkg::T_W-1:0] trial;
			logic                    fit;

			// (m + 2^K)^2 d - m^2 d = 2^(K+1) m d + 2^(2K) d
			assign trial = (gcs_pkg::T_W'(prod_s[i-1]) << (K + 1))
				+ (gcs_pkg::T_W'(den_s[i-1]) << (2 * K));
			assign fit = trial <= gcs_pkg::T_W'(rem_s[i-1]);

			always_ff @(posedge clk) begin
				if (adv) begin
					den_s[i] <= den_s[i-1];
					if (fit) begin
						rem_s[i]  <= rem_s[i-1] - trial[gcs_pkg::R_W-1:0];
						prod_s[i] <= prod_s[i-1] + (gcs_pkg::P_W'(den_s[i-1]) << K);
						quot_s[i] <= quot_s[i-1] | (gcs_pkg::M_W'(1) << K);
					end else begin
						rem_s[i]  <= rem_s[i-1];
						prod_s[i] <= prod_s[i-1];
						quot_s[i] <= quot_s[i-1];
					end
				end
			end
		end
	endgenerate

	assign quot = quot_s[gcs_pkg::M_W];

endmodule
